### design/cfp_pkg.sv
// Package for the command frame parser: phase type, byte codes and length lookup.
package cfp_pkg;

  // Default depth of the payload store.
  localparam int MAX_PAYLOAD_DEF = 11;

  // Sync pair that opens every frame.
  localparam logic [7:0] SYNC_FIRST  = 8'hA5;
  localparam logic [7:0] SYNC_SECOND = 8'h5A;

  // Command codes.
  localparam logic [7:0] CMD_PING      = 8'h01;
  localparam logic [7:0] CMD_STEADY    = 8'h02;
  localparam logic [7:0] CMD_WALK      = 8'h03;
  localparam logic [7:0] CMD_TRANSLATE = 8'h04;
  localparam logic [7:0] CMD_ROTATE    = 8'h05;
  localparam logic [7:0] CMD_REQUEST   = 8'h06;
  localparam logic [7:0] CMD_STATIC    = 8'h07;
  localparam logic [7:0] CMD_GRIPPER   = 8'h08;
  localparam logic [7:0] CMD_SCOOP     = 8'h09;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_SYNC1   = 2'd0,
    PH_SYNC2   = 2'd1,
    PH_COMMAND = 2'd2,
    PH_PAYLOAD = 2'd3
  } hunt_phase_t;

  // Payload length of a command; known is low for an unknown code.
  typedef struct packed {
    logic       known;
    logic [3:0] len;
  } cmd_info_t;

  function automatic cmd_info_t cmd_info(input logic [7:0] code);
    cmd_info_t info;
    info.known = 1'b1;
    info.len   = 4'd0;
    case (code)
      CMD_PING:      info.len = 4'd0;
      CMD_STEADY:    info.len = 4'd0;
      CMD_WALK:      info.len = 4'd10;
      CMD_TRANSLATE: info.len = 4'd4;
      CMD_ROTATE:    info.len = 4'd11;
      CMD_REQUEST:   info.len = 4'd0;
      CMD_STATIC:    info.len = 4'd6;
      CMD_GRIPPER:   info.len = 4'd4;
      CMD_SCOOP:     info.len = 4'd1;
      default:       info.known = 1'b0;
    endcase
    return info;
  endfunction

endpackage

### design/command_frame_parser.sv
// Command frame parser: byte-wise sync hunt, payload capture and result decode.
module command_frame_parser #(
  parameter int MAX_PAYLOAD = cfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_kind,
  output logic signed [15:0] out_value_a,
  output logic signed [15:0] out_value_b,
  output logic signed [15:0] out_value_c,
  output logic signed [15:0] out_value_d,
  output logic signed [7:0]  out_speed,
  output logic [7:0]         out_mode,
  output logic [7:0]         out_walk_points,
  output logic [7:0]         out_extra
);
  // The parser takes one received byte per cycle: in the cycle it is accepted,
  // each byte updates the phase, a payload byte the payload store and a frame's
  // last byte the held gripper and scoop bytes. A frame opens with 0xA5 0x5A and
  // a command byte; the result of a frame is registered and shown on the cycle
  // after its last byte (the command byte for zero-length commands). While a
  // result waits in the output register, in_ready follows out_ready, so bytes
  // keep flowing back to back as long as each result is taken in the cycle it is
  // shown; otherwise the input stalls until the result is taken. Unknown commands
  // and broken sync pairs produce no result. Payload bytes are never searched for sync.

  import cfp_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAYLOAD);

  // Parser state.
  hunt_phase_t phase_r, phase_nxt;
  logic [7:0]  command_code_r, command_code_nxt;
  logic [3:0]  payload_count_r, payload_count_nxt;
  logic [7:0]  store_r [MAX_PAYLOAD];
  logic [7:0]  view [MAX_PAYLOAD];
  logic [7:0]  gripper_r [4];
  logic [7:0]  gripper_nxt [4];
  logic [7:0]  scoop_r, scoop_nxt;

  // Result register.
  logic               out_valid_r;
  logic [3:0]         kind_r, kind_nxt;
  logic signed [15:0] value_a_r, value_a_nxt;
  logic signed [15:0] value_b_r, value_b_nxt;
  logic signed [15:0] value_c_r, value_c_nxt;
  logic signed [15:0] value_d_r, value_d_nxt;
  logic signed [7:0]  speed_r, speed_nxt;
  logic [7:0]         mode_r, mode_nxt;
  logic [7:0]         walk_points_r, walk_points_nxt;
  logic [7:0]         extra_r, extra_nxt;

  logic       accept;
  logic       store_we;
  logic       finish;
  logic [7:0] fin_code;
  logic [3:0] count_inc;
  cmd_info_t  in_info;
  cmd_info_t  cur_info;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign in_info  = cmd_info(in_rx_byte);
  assign cur_info = cmd_info(command_code_r);
  assign count_inc = payload_count_r + 4'd1;

  // Next phase, command code, count and the frame-complete strobe.
  always_comb begin
    phase_nxt         = phase_r;
    command_code_nxt  = command_code_r;
    payload_count_nxt = payload_count_r;
    store_we          = 1'b0;
    finish            = 1'b0;
    fin_code          = command_code_r;
    if (accept) begin
      case (phase_r)
        PH_SYNC1: begin
          if (in_rx_byte == SYNC_FIRST) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (in_rx_byte == SYNC_SECOND) phase_nxt = PH_COMMAND;
          else if (in_rx_byte != SYNC_FIRST) phase_nxt = PH_SYNC1;
        end
        PH_COMMAND: begin
          if (!in_info.known) begin
            phase_nxt = PH_SYNC1;
          end else begin
            command_code_nxt  = in_rx_byte;
            payload_count_nxt = 4'd0;
            fin_code          = in_rx_byte;
            if (in_info.len == 4'd0) begin
              finish    = 1'b1;
              phase_nxt = PH_SYNC1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (!cur_info.known || cur_info.len == 4'd0) begin
            phase_nxt         = PH_SYNC1;
            payload_count_nxt = 4'd0;
          end else begin
            store_we          = int'(payload_count_r) < MAX_PAYLOAD;
            payload_count_nxt = count_inc;
            if (count_inc >= cur_info.len) begin
              finish            = 1'b1;
              phase_nxt         = PH_SYNC1;
              payload_count_nxt = 4'd0;
            end
          end
        end
        default: phase_nxt = PH_SYNC1;
      endcase
    end
  end

  // Payload as seen by the decode, with the byte of this cycle already in place.
  always_comb begin
    for (int i = 0; i < MAX_PAYLOAD; i++) begin
      view[i] = (store_we && payload_count_r[IDX_W-1:0] == IDX_W'(i)) ? in_rx_byte
                                                                        : store_r[i];
    end
  end

  // Result decode and held gripper and scoop bytes.
  always_comb begin
    kind_nxt        = fin_code[3:0] - 4'd1;
    value_a_nxt     = '0;
    value_b_nxt     = '0;
    value_c_nxt     = '0;
    value_d_nxt     = '0;
    speed_nxt       = '0;
    mode_nxt        = '0;
    walk_points_nxt = '0;
    extra_nxt       = '0;
    for (int j = 0; j < 4; j++) gripper_nxt[j] = gripper_r[j];
    scoop_nxt = scoop_r;
    case (fin_code)
      CMD_WALK: begin
        value_a_nxt     = {view[0], view[1]};
        value_b_nxt     = {view[2], view[3]};
        value_c_nxt     = {view[4], view[5]};
        speed_nxt       = view[6];
        mode_nxt        = view[7];
        walk_points_nxt = view[8];
        extra_nxt       = view[9];
      end
      CMD_TRANSLATE: begin
        value_a_nxt = {{8{view[0][7]}}, view[0]};
        value_b_nxt = {{8{view[1][7]}}, view[1]};
        mode_nxt    = view[2];
        extra_nxt   = view[3];
      end
      CMD_ROTATE: begin
        value_a_nxt     = {view[0], view[1]};
        value_b_nxt     = {view[2], view[3]};
        value_c_nxt     = {view[4], view[5]};
        value_d_nxt     = {view[6], view[7]};
        mode_nxt        = view[8];
        speed_nxt       = view[9];
        walk_points_nxt = view[10];
      end
      CMD_STATIC: begin
        value_a_nxt = {view[0], view[1]};
        value_b_nxt = {view[2], view[3]};
        value_c_nxt = {view[4], view[5]};
      end
      CMD_GRIPPER: begin
        // A held byte changes only on a nonzero payload byte.
        for (int j = 0; j < 4; j++) begin
          if (view[j] != 8'd0) gripper_nxt[j] = view[j];
        end
        value_a_nxt = {8'd0, gripper_nxt[0]};
        value_b_nxt = {8'd0, gripper_nxt[1]};
        value_c_nxt = {8'd0, gripper_nxt[2]};
        value_d_nxt = {8'd0, gripper_nxt[3]};
      end
      CMD_SCOOP: begin
        if (view[0] != 8'd0) scoop_nxt = view[0];
        value_a_nxt = {8'd0, scoop_nxt};
      end
      default: ;
    endcase
  end

  // Control state and held bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_SYNC1;
      command_code_r  <= 8'd0;
      payload_count_r <= 4'd0;
      scoop_r         <= 8'd0;
      out_valid_r     <= 1'b0;
      for (int j = 0; j < 4; j++) gripper_r[j] <= 8'd0;
    end else begin
      phase_r         <= phase_nxt;
      command_code_r  <= command_code_nxt;
      payload_count_r <= payload_count_nxt;
      if (finish) begin
        scoop_r <= scoop_nxt;
        for (int j = 0; j < 4; j++) gripper_r[j] <= gripper_nxt[j];
      end
      if (finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload store.
  always_ff @(posedge clk) begin
    if (store_we) store_r[payload_count_r[IDX_W-1:0]] <= in_rx_byte;
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (finish) begin
      kind_r        <= kind_nxt;
      value_a_r     <= value_a_nxt;
      value_b_r     <= value_b_nxt;
      value_c_r     <= value_c_nxt;
      value_d_r     <= value_d_nxt;
      speed_r       <= speed_nxt;
      mode_r        <= mode_nxt;
      walk_points_r <= walk_points_nxt;
      extra_r       <= extra_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_value_a     = value_a_r;
  assign out_value_b     = value_b_r;
  assign out_value_c     = value_c_r;
  assign out_value_d     = value_d_r;
  assign out_speed       = speed_r;
  assign out_mode        = mode_r;
  assign out_walk_points = walk_points_r;
  assign out_extra       = extra_r;

`ifndef ASSERT_OFF
  // A new result only follows an accepted byte.
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept))
    else $error("result appeared without an accepted item");

  // While collecting, the held command is known and the count is below its length.
  a_payload_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (cur_info.known && payload_count_r < cur_info.len))
    else $error("payload phase with bad command or count");

  // A finished frame always returns the parser to sync hunting.
  a_finish_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> (phase_r == PH_SYNC1 && payload_count_r == 4'd0))
    else $error("parser did not return to hunting after a frame");
`endif

endmodule
